@@ src/xalu_pkg.sv @@
// Shared types and codes for the x86 integer ALU with flags.
package xalu_pkg;

  // Operation codes carried in req_type.
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_ADC  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_SBB  = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd4;
  localparam logic [3:0] OP_OR   = 4'd5;
  localparam logic [3:0] OP_XOR  = 4'd6;
  localparam logic [3:0] OP_SHL  = 4'd7;
  localparam logic [3:0] OP_SHR  = 4'd8;
  localparam logic [3:0] OP_SAR  = 4'd9;
  localparam logic [3:0] OP_IMUL = 4'd10;

  // Operand size codes; any other code means 32 bits.
  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] src_operand;
    logic [31:0] dest_operand;
    logic [1:0]  size_code;
    logic        carry_in;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        carry_out;
    logic        overflow_out;
    logic        zero_out;
    logic        sign_out;
    logic        parity_out;
    logic        writes_main_flags;
    logic        writes_overflow;
  } alu_res_t;

endpackage

@@ src/x86_integer_alu_with_flags.sv @@
// x86 integer ALU: add/adc/sub/sbb, logic, shifts and imul with flag generation.
//
// A request is taken whenever start is high; busy is always low, so one request
// may follow another in every clock cycle. Each request passes through an input
// register and one stage of combinational logic (adder, barrel shifter, or a
// 32 by 32 signed multiplier) into the result register. Its result is shown on
// the out_ ports, marked by out_valid, for a single cycle once the result register
// holds it. Results come out in request order and the receiver has to take each
// one in the cycle it is shown.
module x86_integer_alu_with_flags (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  xalu_pkg::alu_req_t in_req,
  output logic               out_valid,
  output xalu_pkg::alu_res_t out_res
);

  xalu_pkg::alu_req_t req_r;
  logic               vld_r;
  xalu_pkg::alu_res_t out_r;
  xalu_pkg::alu_res_t out_nxt;
  logic               out_valid_r;

  logic [31:0]        msk;
  logic [31:0]        s_op;
  logic [31:0]        d_op;
  logic               cin;
  logic [32:0]        sum;
  logic [32:0]        diff;
  logic [32:0]        shl_v;
  logic [31:0]        shr_v;
  logic signed [31:0] se_s;
  logic signed [31:0] se_d;
  logic signed [31:0] sar_v;
  logic signed [63:0] prod;
  logic [4:0]         cnt;
  logic [4:0]         cnt_m1;

  // Top bit of a value at the current operand size.
  function automatic logic sized_msb(input logic [31:0] v, input logic [1:0] sz);
    logic b;
    unique case (sz)
      xalu_pkg::SZ_8:  b = v[7];
      xalu_pkg::SZ_16: b = v[15];
      default:         b = v[31];
    endcase
    return b;
  endfunction

  // Bit just above the operand size: the carry or borrow out.
  function automatic logic sized_carry(input logic [32:0] v, input logic [1:0] sz);
    logic b;
    unique case (sz)
      xalu_pkg::SZ_8:  b = v[8];
      xalu_pkg::SZ_16: b = v[16];
      default:         b = v[32];
    endcase
    return b;
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= start;
      out_valid_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= in_req;
    end
    if (vld_r) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    unique case (req_r.size_code)
      xalu_pkg::SZ_8:  msk = 32'h0000_00FF;
      xalu_pkg::SZ_16: msk = 32'h0000_FFFF;
      default:         msk = 32'hFFFF_FFFF;
    endcase
  end

  assign s_op = req_r.src_operand & msk;
  assign d_op = req_r.dest_operand & msk;
  assign cin  = ((req_r.req_type == xalu_pkg::OP_ADC) ||
                 (req_r.req_type == xalu_pkg::OP_SBB)) ? req_r.carry_in : 1'b0;

  // With both operands masked, bit w of the 33-bit difference is the borrow.
  assign sum  = {1'b0, d_op} + {1'b0, s_op} + {32'b0, cin};
  assign diff = {1'b0, d_op} - {1'b0, s_op} - {32'b0, cin};

  always_comb begin
    unique case (req_r.size_code)
      xalu_pkg::SZ_8: begin
        se_s = {{24{s_op[7]}}, s_op[7:0]};
        se_d = {{24{d_op[7]}}, d_op[7:0]};
      end
      xalu_pkg::SZ_16: begin
        se_s = {{16{s_op[15]}}, s_op[15:0]};
        se_d = {{16{d_op[15]}}, d_op[15:0]};
      end
      default: begin
        se_s = s_op;
        se_d = d_op;
      end
    endcase
  end

  assign cnt    = req_r.src_operand[4:0];
  assign cnt_m1 = cnt - 5'd1;
  assign shl_v  = {1'b0, d_op} << cnt;
  assign shr_v  = d_op >> cnt;
  assign sar_v  = se_d >>> cnt;
  assign prod   = se_s * se_d;

  always_comb begin
    logic [31:0] res;
    logic        cf;
    logic        of;
    logic        flg;
    logic        wof;
    res     = 32'b0;
    cf      = 1'b0;
    of      = 1'b0;
    flg     = 1'b0;
    wof     = 1'b0;
    out_nxt = '0;
    unique case (req_r.req_type)
      xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
        res = sum[31:0] & msk;
        cf  = sized_carry(sum, req_r.size_code);
        of  = (sized_msb(s_op, req_r.size_code) == sized_msb(d_op, req_r.size_code)) &&
              (sized_msb(res, req_r.size_code) != sized_msb(s_op, req_r.size_code));
        flg = 1'b1;
        wof = 1'b1;
      end
      xalu_pkg::OP_SUB, xalu_pkg::OP_SBB: begin
        res = diff[31:0] & msk;
        cf  = sized_carry(diff, req_r.size_code);
        of  = (sized_msb(s_op, req_r.size_code) != sized_msb(d_op, req_r.size_code)) &&
              (sized_msb(res, req_r.size_code) != sized_msb(d_op, req_r.size_code));
        flg = 1'b1;
        wof = 1'b1;
      end
      xalu_pkg::OP_AND: begin
        res = s_op & d_op;
        flg = 1'b1;
        wof = 1'b1;
      end
      xalu_pkg::OP_OR: begin
        res = s_op | d_op;
        flg = 1'b1;
        wof = 1'b1;
      end
      xalu_pkg::OP_XOR: begin
        res = s_op ^ d_op;
        flg = 1'b1;
        wof = 1'b1;
      end
      xalu_pkg::OP_SHL: begin
        res = shl_v[31:0] & msk;
        cf  = sized_carry(shl_v, req_r.size_code);
        flg = (cnt != 5'd0);
      end
      xalu_pkg::OP_SHR: begin
        res = shr_v;
        cf  = d_op[cnt_m1];
        flg = (cnt != 5'd0);
      end
      xalu_pkg::OP_SAR: begin
        res = sar_v & msk;
        cf  = se_d[cnt_m1];
        flg = (cnt != 5'd0);
      end
      default: begin
        res = 32'b0;
      end
    endcase

    if (req_r.req_type == xalu_pkg::OP_IMUL) begin
      unique case (req_r.size_code)
        xalu_pkg::SZ_8:  out_nxt.result_value = {48'b0, prod[15:0]};
        xalu_pkg::SZ_16: out_nxt.result_value = {32'b0, prod[31:0]};
        default:         out_nxt.result_value = prod;
      endcase
    end else begin
      out_nxt.result_value = {32'b0, res};
    end

    // A shift by zero, imul and unknown codes leave every flag field at zero.
    out_nxt.carry_out         = flg & cf;
    out_nxt.overflow_out      = flg & of;
    out_nxt.zero_out          = flg & (res == 32'b0);
    out_nxt.sign_out          = flg & sized_msb(res, req_r.size_code);
    out_nxt.parity_out        = flg & ~(^res[7:0]);
    out_nxt.writes_main_flags = flg;
    out_nxt.writes_overflow   = wof;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid)
    else $error("accepted request did not produce a result two cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r))
    else $error("result strobe without a request in the input register");

  a_of_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.writes_overflow |-> out_res.writes_main_flags)
    else $error("OF written without the main flags");

  a_quiet_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.writes_main_flags |->
      !out_res.carry_out && !out_res.overflow_out && !out_res.zero_out &&
      !out_res.sign_out && !out_res.parity_out)
    else $error("flag fields set on a request that writes no flags");

  a_narrow_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.writes_main_flags |-> out_res.result_value[63:32] == 32'b0)
    else $error("flag-writing request gave a result wider than 32 bits");

endmodule

@@ verif/x86_integer_alu_with_flags_tb.sv @@
// Self-checking testbench for the x86 integer ALU with flags.
module x86_integer_alu_with_flags_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_LIMIT = 200;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  xalu_pkg::alu_req_t in_req = '0;
  logic               out_valid;
  xalu_pkg::alu_res_t out_res;

  int unsigned cycles = 0;
  int unsigned directed_count = 0;

  x86_integer_alu_with_flags dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  class alu_result_board;
    xalu_pkg::alu_res_t pending_results[$];
    int unsigned        errors = 0;
    int unsigned        taken = 0;
    int unsigned        checked = 0;

    static function xalu_pkg::alu_res_t compute_alu_flags(xalu_pkg::alu_req_t r);
      xalu_pkg::alu_res_t o;
      int unsigned w;
      int unsigned sb;
      int unsigned cnt;
      logic [63:0] m;
      logic [63:0] m2;
      logic [63:0] s;
      logic [63:0] d;
      logic [63:0] c;
      logic [63:0] full;
      logic [63:0] res;
      logic [63:0] e;
      logic        cf;
      logic        of;
      logic        fl;
      logic        wmain;
      logic        wof;
      w = (r.size_code == xalu_pkg::SZ_8) ? 8 : (r.size_code == xalu_pkg::SZ_16) ? 16 : 32;
      sb = w - 1;
      m = (64'd1 << w) - 64'd1;
      m2 = (w == 32) ? {64{1'b1}} : ((64'd1 << (2 * w)) - 64'd1);
      s = {32'd0, r.src_operand} & m;
      d = {32'd0, r.dest_operand} & m;
      c = ((r.req_type == xalu_pkg::OP_ADC) || (r.req_type == xalu_pkg::OP_SBB)) ?
          {63'd0, r.carry_in} : 64'd0;
      cnt = {27'd0, r.src_operand[4:0]};
      res = '0;
      cf = 1'b0;
      of = 1'b0;
      fl = 1'b0;
      wmain = 1'b0;
      wof = 1'b0;
      case (r.req_type)
        xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
          full = d + s + c;
          res = full & m;
          cf = full[w];
          of = (s[sb] == d[sb]) && (res[sb] != s[sb]);
          fl = 1'b1; wmain = 1'b1; wof = 1'b1;
        end
        xalu_pkg::OP_SUB, xalu_pkg::OP_SBB: begin
          res = (d - s - c) & m;
          cf = d < (s + c);
          of = (s[sb] != d[sb]) && (res[sb] != d[sb]);
          fl = 1'b1; wmain = 1'b1; wof = 1'b1;
        end
        xalu_pkg::OP_AND, xalu_pkg::OP_OR, xalu_pkg::OP_XOR: begin
          if (r.req_type == xalu_pkg::OP_AND) res = s & d;
          else if (r.req_type == xalu_pkg::OP_OR) res = s | d;
          else res = s ^ d;
          fl = 1'b1; wmain = 1'b1; wof = 1'b1;
        end
        xalu_pkg::OP_SHL, xalu_pkg::OP_SHR, xalu_pkg::OP_SAR: begin
          // A zero count passes the operand through and touches no flag.
          if (cnt == 0) begin
            res = d;
          end else begin
            if (r.req_type == xalu_pkg::OP_SHL) begin
              full = d << cnt;
              res = full & m;
              cf = full[w];
            end else if (r.req_type == xalu_pkg::OP_SHR) begin
              res = d >> cnt;
              cf = d[cnt - 1];
            end else begin
              e = d[sb] ? (d | ~m) : d;
              full = $signed(e) >>> cnt;
              res = full & m;
              cf = e[cnt - 1];
            end
            fl = 1'b1; wmain = 1'b1;
          end
        end
        xalu_pkg::OP_IMUL: begin
          e = s[sb] ? (s | ~m) : s;
          full = d[sb] ? (d | ~m) : d;
          res = (e * full) & m2;
        end
        default: begin
          res = '0;
        end
      endcase
      o.result_value = res;
      o.carry_out = fl & cf;
      o.overflow_out = fl & of;
      o.zero_out = fl & ((res & m) == 64'd0);
      o.sign_out = fl & res[sb];
      o.parity_out = fl & ~(^res[7:0]);
      o.writes_main_flags = wmain;
      o.writes_overflow = wof;
      return o;
    endfunction

    function void note_request(xalu_pkg::alu_req_t r);
      pending_results.push_back(compute_alu_flags(r));
      taken++;
    endfunction

    function void field_diff(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(xalu_pkg::alu_res_t got);
      xalu_pkg::alu_res_t want;
      if (pending_results.size() == 0) begin
        $error("result %h arrived with no request outstanding", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      field_diff("result_value", want.result_value, got.result_value);
      field_diff("carry_out", 64'(want.carry_out), 64'(got.carry_out));
      field_diff("overflow_out", 64'(want.overflow_out), 64'(got.overflow_out));
      field_diff("zero_out", 64'(want.zero_out), 64'(got.zero_out));
      field_diff("sign_out", 64'(want.sign_out), 64'(got.sign_out));
      field_diff("parity_out", 64'(want.parity_out), 64'(got.parity_out));
      field_diff("writes_main_flags", 64'(want.writes_main_flags),
                 64'(got.writes_main_flags));
      field_diff("writes_overflow", 64'(want.writes_overflow), 64'(got.writes_overflow));
    endfunction
  endclass

  alu_result_board board = new();

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Inputs change only through nonblocking assignments, so values read here
  // are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_request(in_req);
    if (rst_n && out_valid) board.check_result(out_res);
  end

  function automatic xalu_pkg::alu_req_t mk_req(logic [3:0] op, logic [31:0] src,
                                                logic [31:0] dst, logic [1:0] sz,
                                                logic cin);
    xalu_pkg::alu_req_t r;
    r.req_type = op;
    r.src_operand = src;
    r.dest_operand = dst;
    r.size_code = sz;
    r.carry_in = cin;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand(logic [1:0] sz);
    int unsigned w;
    logic [31:0] top;
    w = (sz == xalu_pkg::SZ_8) ? 8 : (sz == xalu_pkg::SZ_16) ? 16 : 32;
    top = 32'd1 << (w - 1);
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return top | ($urandom() & ~((top << 1) - 32'd1));
      3: return (top - 32'd1) | ($urandom() & ~((top << 1) - 32'd1));
      4: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic xalu_pkg::alu_req_t rand_request();
    xalu_pkg::alu_req_t r;
    int unsigned w;
    logic [4:0] cnt;
    r.req_type = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10));
    r.size_code = ($urandom_range(0, 99) < 8) ? 2'd3 : 2'($urandom_range(0, 2));
    r.dest_operand = rand_operand(r.size_code);
    r.carry_in = 1'($urandom_range(0, 1));
    if ((r.req_type == xalu_pkg::OP_SHL) || (r.req_type == xalu_pkg::OP_SHR) ||
        (r.req_type == xalu_pkg::OP_SAR)) begin
      w = (r.size_code == xalu_pkg::SZ_8) ? 8 : (r.size_code == xalu_pkg::SZ_16) ? 16 : 32;
      // Weight the count towards zero and the edges of the operand size.
      case ($urandom_range(0, 5))
        0: cnt = 5'd0;
        1: cnt = 5'(w - 1);
        2: cnt = 5'(w);
        3: cnt = 5'd1;
        default: cnt = 5'($urandom_range(0, 31));
      endcase
      r.src_operand = {27'($urandom()), cnt};
    end else begin
      r.src_operand = rand_operand(r.size_code);
    end
    return r;
  endfunction

  // Called at a rising edge; returns at the edge that takes the request.
  task automatic send_req(xalu_pkg::alu_req_t r);
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_random(int unsigned n, int unsigned idle_pct);
    for (int unsigned i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        in_req <= rand_request();
        @(posedge clk);
      end
      send_req(rand_request());
    end
  endtask

  task automatic run_directed();
    xalu_pkg::alu_req_t reqs[$];
    reqs.push_back(mk_req(xalu_pkg::OP_ADD, 32'h01, 32'h7F, xalu_pkg::SZ_8, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_ADD, 32'h01, 32'hFF, xalu_pkg::SZ_8, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_ADC, 32'h0000, 32'hFFFF, xalu_pkg::SZ_16, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_ADC, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          xalu_pkg::SZ_32, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_SUB, 32'h1, 32'h0, xalu_pkg::SZ_32, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_SUB, 32'h1, 32'h8000, xalu_pkg::SZ_16, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_SBB, 32'h00, 32'h80, xalu_pkg::SZ_8, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_SBB, 32'h1234_5678, 32'h1234_5678,
                          xalu_pkg::SZ_32, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_SBB, 32'hFFFF_FFFF, 32'h0, xalu_pkg::SZ_32, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          xalu_pkg::SZ_32, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_OR, 32'h0, 32'h0, xalu_pkg::SZ_8, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_XOR, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                          xalu_pkg::SZ_16, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_SHL, 32'hFFFF_FFE0, 32'h80, xalu_pkg::SZ_8, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_SHL, 32'h1, 32'h80, xalu_pkg::SZ_8, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_SHL, 32'd20, 32'hFF, xalu_pkg::SZ_8, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_SHR, 32'd31, 32'hFFFF_FFFF, xalu_pkg::SZ_32, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_SHR, 32'd0, 32'hFFFF_1234, xalu_pkg::SZ_16, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_SAR, 32'd31, 32'h8000, xalu_pkg::SZ_16, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_SAR, 32'd12, 32'h80, xalu_pkg::SZ_8, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_IMUL, 32'h80, 32'h80, xalu_pkg::SZ_8, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_IMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          xalu_pkg::SZ_32, 1'b1));
    reqs.push_back(mk_req(xalu_pkg::OP_IMUL, 32'h8000_0000, 32'h8000_0000, 2'd3, 1'b0));
    reqs.push_back(mk_req(xalu_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 2'd3, 1'b0));
    reqs.push_back(mk_req(4'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, xalu_pkg::SZ_32, 1'b1));
    reqs.push_back(mk_req(4'd15, 32'h1, 32'h1, xalu_pkg::SZ_8, 1'b0));
    foreach (reqs[i]) send_req(reqs[i]);
    directed_count = reqs.size();
  endtask

  initial begin
    int unsigned drain;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(620, 26);
    run_random(615, 82);
    run_random(615, 0);
    start <= 1'b0;

    drain = 0;
    while ((board.pending_results.size() != 0) && (drain < DRAIN_LIMIT)) begin
      @(posedge clk);
      drain++;
    end
    // Keep clocking before the final check so that any stray result would still be seen.
    repeat (6) @(posedge clk);
    if (board.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", board.pending_results.size());
      board.errors++;
    end

    $display("Ran %0d requests, %0d of them directed, over every operation, unused codes",
             board.taken, directed_count);
    $display("and sizes under three sender idle profiles; %0d results compared.",
             board.checked);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/xalu_pkg.sv
src/x86_integer_alu_with_flags.sv
verif/x86_integer_alu_with_flags_tb.sv
